/* hdl/pcre_pkg.sv */
// Shared types and constants for the ping and clock rift estimator.
// Holds field structs, op and register codes, reset values and fixed-point constants.
// No dependencies.
`default_nettype none

package pcre_pkg;

  localparam int FRAME_SHIFT = 5;
  localparam int FRAC_BITS   = 8;

  // event selector
  localparam logic [1:0] OP_PING  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // register index, paddr[3:2]
  localparam logic [1:0] REG_PING_WEIGHT = 2'd0;
  localparam logic [1:0] REG_RIFT_WEIGHT = 2'd1;
  localparam logic [1:0] REG_PING_CAP    = 2'd2;
  localparam logic [1:0] REG_RIFT_LIMIT  = 2'd3;

  localparam logic [15:0] PING_WEIGHT_RST = 16'd6554;
  localparam logic [15:0] RIFT_WEIGHT_RST = 16'd3277;
  localparam logic [7:0]  PING_CAP_RST    = 8'd255;
  localparam logic [12:0] RIFT_LIMIT_RST  = 13'd5120;

  localparam logic [15:0]        PING_TOP   = 16'(255 << FRAC_BITS);
  localparam logic signed [31:0] RIFT_ONE   = 32'(1 << FRAC_BITS);
  localparam logic [6:0]         TINY_SCALE = 7'd100;
  localparam logic [20:0]        TINY_LIMIT = 21'(1 << FRAC_BITS);

  typedef struct packed {
    logic [15:0] ping_weight;
    logic [15:0] rift_weight;
    logic [7:0]  ping_cap_ms;
    logic [12:0] rift_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] rtt_ms;
    logic [31:0] client_frame;
    logic [31:0] server_frame;
  } item_t;

  typedef struct packed {
    logic        ping_seen;
    logic [15:0] ping_avg;
    logic [7:0]  ping_shown;
    logic        fresh_ping;
    logic        fresh_frame;
    logic [31:0] peer_frame;
    logic        rift_seen;
    logic [13:0] rift_avg;
    logic [31:0] rift_last_raw;
  } state_t;

endpackage

`default_nettype wire

/* hdl/pcre_update.sv */
// Next-state logic of the estimator: one event applied to the tracked state.
// Purely combinational; uses pcre_pkg types and constants.
`default_nettype none

module pcre_update (
  input  pcre_pkg::cfg_t   cfg,
  input  pcre_pkg::state_t st,
  input  pcre_pkg::item_t  item,
  output pcre_pkg::state_t st_next,
  output logic             upd
);

  // ---- ping sample ----
  logic               rtt_neg;
  logic [7:0]         sample;
  logic [15:0]        big;
  logic signed [16:0] diff_p;
  logic signed [33:0] prod_p;
  logic signed [33:0] rnd_p;
  logic signed [17:0] adj_p;
  logic signed [17:0] ewma_p;
  logic [15:0]        ping_new;

  assign rtt_neg = item.rtt_ms[15];
  assign sample  = (item.rtt_ms[14:0] > {7'd0, cfg.ping_cap_ms}) ? cfg.ping_cap_ms
                                                                 : item.rtt_ms[7:0];
  assign big     = 16'(sample) << pcre_pkg::FRAC_BITS;

  // a*S + (1-a)*avg rewritten as avg + a*(S - avg)
  assign diff_p  = $signed({1'b0, big}) - $signed({1'b0, st.ping_avg});
  assign prod_p  = $signed({1'b0, cfg.ping_weight}) * diff_p;
  assign rnd_p   = prod_p + 34'sd32768;
  assign adj_p   = rnd_p[33:16];
  assign ewma_p  = $signed({2'b00, st.ping_avg}) + adj_p;

  always_comb begin
    if (!st.ping_seen) begin
      ping_new = big;
    end else if (ewma_p > $signed({2'b00, pcre_pkg::PING_TOP})) begin
      ping_new = pcre_pkg::PING_TOP;
    end else begin
      ping_new = ewma_p[15:0];
    end
  end

  // ---- rift ----
  logic               fire;
  logic signed [32:0] frame_dif;
  logic signed [41:0] raw_ext;
  logic signed [41:0] raw_full;
  logic signed [31:0] raw;
  logic signed [13:0] avg;
  logic               raw_small;
  logic signed [14:0] avg_adj;
  logic signed [13:0] half;
  logic [13:0]        half_mag;
  logic [20:0]        tiny_prod;
  logic signed [13:0] half_snap;
  logic signed [32:0] diff_r;
  logic signed [49:0] prod_r;
  logic signed [49:0] rnd_r;
  logic signed [33:0] adj_r;
  logic signed [33:0] cand;
  logic signed [33:0] lim;
  logic [13:0]        rift_new;

  assign fire      = st.fresh_ping & st.fresh_frame;
  assign frame_dif = $signed({1'b0, st.peer_frame}) - $signed({1'b0, item.server_frame});
  assign raw_ext   = {{9{frame_dif[32]}}, frame_dif};
  assign raw_full  = (raw_ext <<< pcre_pkg::FRAC_BITS)
                   + $signed({26'd0, st.ping_avg >> pcre_pkg::FRAME_SHIFT});

  always_comb begin
    if (!raw_full[41] && (|raw_full[40:31])) begin
      raw = 32'sh7FFF_FFFF;
    end else if (raw_full[41] && !(&raw_full[40:31])) begin
      raw = 32'sh8000_0000;
    end else begin
      raw = raw_full[31:0];
    end
  end

  assign avg       = $signed(st.rift_avg);
  assign raw_small = (raw < pcre_pkg::RIFT_ONE) && (raw > -pcre_pkg::RIFT_ONE);

  // halve toward zero, then snap tiny values to zero
  assign avg_adj   = $signed({avg[13], avg}) + $signed({14'd0, avg[13]});
  assign half      = avg_adj[14:1];
  assign half_mag  = half[13] ? 14'(-half) : half;
  assign tiny_prod = 21'(half_mag) * 21'(pcre_pkg::TINY_SCALE);
  assign half_snap = (tiny_prod < pcre_pkg::TINY_LIMIT) ? 14'sd0 : half;

  assign diff_r = $signed({raw[31], raw}) - $signed({{19{avg[13]}}, avg});
  assign prod_r = $signed({1'b0, cfg.rift_weight}) * diff_r;
  assign rnd_r  = prod_r + 50'sd32768;
  assign adj_r  = rnd_r[49:16];
  assign lim    = $signed({21'd0, cfg.rift_limit});

  always_comb begin
    priority if (!st.rift_seen) begin
      cand = $signed({{2{raw[31]}}, raw});
    end else if (raw_small) begin
      cand = $signed({{20{half_snap[13]}}, half_snap});
    end else begin
      cand = $signed({{20{avg[13]}}, avg}) + adj_r;
    end
    if (cand > lim) begin
      rift_new = lim[13:0];
    end else if (cand < -lim) begin
      rift_new = 14'(-lim);
    end else begin
      rift_new = cand[13:0];
    end
  end

  // ---- event select ----
  always_comb begin
    st_next = st;
    upd     = 1'b0;
    unique case (item.op)
      pcre_pkg::OP_PING: begin
        if (!rtt_neg) begin
          st_next.ping_seen  = 1'b1;
          st_next.ping_avg   = ping_new;
          st_next.ping_shown = sample;
          st_next.fresh_ping = 1'b1;
        end
      end
      pcre_pkg::OP_FRAME: begin
        st_next.peer_frame  = item.client_frame;
        st_next.fresh_frame = 1'b1;
      end
      pcre_pkg::OP_TICK: begin
        if (fire) begin
          upd                 = 1'b1;
          st_next.rift_seen   = 1'b1;
          st_next.rift_avg    = rift_new;
          if (st.rift_seen) begin
            st_next.rift_last_raw = raw;
          end
          st_next.ping_shown  = 8'(st.ping_avg >> pcre_pkg::FRAC_BITS);
          st_next.fresh_ping  = 1'b0;
          st_next.fresh_frame = 1'b0;
        end
      end
      pcre_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ping_and_clock_rift_estimator_core.sv */
// Top level of the ping and clock rift estimator: stream ports, APB registers,
// input and result registers and the tracked state. Uses pcre_pkg and pcre_update.
//
// Usage:
//   Events enter on the s_ stream, one word per event; s_tuser carries the op
//   (ping sample, client frame report, tick, no-op). Every event yields exactly
//   one result word on the m_ stream with the state after the event applied.
//   Flow: an accepted word is held in the input register, then applied to the
//   state and written to the result register when that register is free,
//   which raises m_tvalid.
//   Throughput: one event per cycle unless the result stream stalls. The whole
//   update, including the 17x33 EWMA multiply for the rift and the 42-bit raw
//   rift add, sits between the input and result registers, so nothing iterates.
//   Stall: while m_tready is low the result register holds; one more word is
//   taken into the input register, then s_tready drops until the result leaves.
//   Reset (rst, synchronous): state clears to zero, registers take their reset
//   weights, cap and limit, both stream registers empty.
//   Registers (APB, byte address 4*i): ping weight, rift weight, ping_cap_ms,
//   rift_limit. Write them only while no event is in flight.
`default_nettype none

module ping_and_clock_rift_estimator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // event stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // rtt_ms[15:0], client_frame[47:16], server_frame[79:48]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // smoothed_ping[15:0], reported_ping[23:16],
                                      // smooth_rift[37:24], raw_rift[69:38], zero[71:70]
  output logic [0:0]       m_tuser,   // rift_updated[0]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  pcre_pkg::cfg_t   cfg;
  pcre_pkg::state_t st;
  pcre_pkg::state_t st_next;
  pcre_pkg::item_t  in_item;
  logic             in_valid;
  logic             upd_next;
  logic             advance;
  logic             cfg_wr;

  // ---- configuration ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ping_weight <= pcre_pkg::PING_WEIGHT_RST;
      cfg.rift_weight <= pcre_pkg::RIFT_WEIGHT_RST;
      cfg.ping_cap_ms <= pcre_pkg::PING_CAP_RST;
      cfg.rift_limit  <= pcre_pkg::RIFT_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pcre_pkg::REG_PING_WEIGHT: cfg.ping_weight <= pwdata[15:0];
        pcre_pkg::REG_RIFT_WEIGHT: cfg.rift_weight <= pwdata[15:0];
        pcre_pkg::REG_PING_CAP:    cfg.ping_cap_ms <= pwdata[7:0];
        pcre_pkg::REG_RIFT_LIMIT:  cfg.rift_limit  <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pcre_pkg::REG_PING_WEIGHT: prdata = {16'd0, cfg.ping_weight};
      pcre_pkg::REG_RIFT_WEIGHT: prdata = {16'd0, cfg.rift_weight};
      pcre_pkg::REG_PING_CAP:    prdata = {24'd0, cfg.ping_cap_ms};
      pcre_pkg::REG_RIFT_LIMIT:  prdata = {19'd0, cfg.rift_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  // ---- pipeline control ----
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op           <= s_tuser;
      in_item.rtt_ms       <= s_tdata[15:0];
      in_item.client_frame <= s_tdata[47:16];
      in_item.server_frame <= s_tdata[79:48];
    end
  end

  pcre_update u_update (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .upd     (upd_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, st_next.rift_last_raw, st_next.rift_avg,
                  st_next.ping_shown, st_next.ping_avg};
      m_tuser <= upd_next;
    end
  end

  // ---- checks ----
  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input held back without a stalled result");

  a_fresh_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && upd_next) |=> (!st.fresh_ping && !st.fresh_frame))
    else $error("fresh flags survive a rift update");

  a_ping_top: assert property (@(posedge clk) disable iff (rst)
    st.ping_avg <= pcre_pkg::PING_TOP)
    else $error("smoothed ping above cap");

  a_upd_tick: assert property (@(posedge clk) disable iff (rst)
    (advance && upd_next) |-> (in_item.op == pcre_pkg::OP_TICK && st.fresh_ping))
    else $error("rift update outside a tick");

endmodule

`default_nettype wire

/* bench/ping_and_clock_rift_estimator_core_tb.sv */
// Self-checking bench for ping_and_clock_rift_estimator_core: event words in, result words out,
// each result checked against an in-bench estimate of ping and rift state.
// Depends on pcre_pkg and the core RTL.
`default_nettype none

module ping_and_clock_rift_estimator_core_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RIFT_SMALL  = 0;  // |raw| at most one frame
  localparam int RIFT_NEAR   = 1;  // a few dozen frames off
  localparam int RIFT_WIDE   = 2;  // any server frame, often saturating
  localparam longint RAW_MAX = 64'sd2147483647;
  localparam longint RAW_MIN = -64'sd2147483648;

  typedef struct {
    logic [15:0]        smoothed_ping;
    logic [7:0]         reported_ping;
    logic signed [13:0] smooth_rift;
    logic [31:0]        raw_rift;
    logic               rift_updated;
  } rift_report_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [79:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [71:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  ping_and_clock_rift_estimator_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register shadow
  logic [15:0] cfg_ping_weight, cfg_rift_weight;
  logic [7:0]  cfg_ping_cap;
  logic [12:0] cfg_rift_limit;

  // estimator state
  logic               est_ping_seen, est_fresh_ping, est_fresh_frame, est_rift_seen;
  logic [15:0]        est_ping_avg;
  logic [7:0]         est_ping_shown;
  logic [31:0]        est_peer_frame;
  logic signed [13:0] est_rift_avg;
  logic [31:0]        est_last_raw;

  rift_report_t pending_reports[$];
  int  bad_words = 0;
  int  clk_count = 0;
  bit  tx_idle = 1, rx_idle = 1;
  int  hold_len = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    clk_count <= clk_count + 1;
    if (clk_count == CYCLE_LIMIT) begin
      $display("ping_and_clock_rift_estimator_core: mismatch");
      $finish;
    end
  end

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic reset_estimate;
    cfg_ping_weight = pcre_pkg::PING_WEIGHT_RST;
    cfg_rift_weight = pcre_pkg::RIFT_WEIGHT_RST;
    cfg_ping_cap    = pcre_pkg::PING_CAP_RST;
    cfg_rift_limit  = pcre_pkg::RIFT_LIMIT_RST;
    est_ping_seen   = 1'b0;
    est_fresh_ping  = 1'b0;
    est_fresh_frame = 1'b0;
    est_rift_seen   = 1'b0;
    est_ping_avg    = '0;
    est_ping_shown  = '0;
    est_peer_frame  = '0;
    est_rift_avg    = '0;
    est_last_raw    = '0;
  endtask

  // apply one event to the estimate and queue the report it yields
  task automatic track_event(input logic [1:0] op, input logic [15:0] rtt,
                             input logic [31:0] cf, input logic [31:0] sf);
    longint s, nxt, wa, top, raw, avg, wb, lim, pf64, sf64;
    rift_report_t rep;
    logic upd;
    upd = 1'b0;
    case (op)
      pcre_pkg::OP_PING: if (!rtt[15]) begin
        s = {48'd0, rtt};
        if (s > {56'd0, cfg_ping_cap}) s = {56'd0, cfg_ping_cap};
        wa = {48'd0, cfg_ping_weight};
        top = {48'd0, pcre_pkg::PING_TOP};
        if (!est_ping_seen) begin
          nxt = s <<< pcre_pkg::FRAC_BITS;
          est_ping_seen = 1'b1;
        end else begin
          nxt = (wa * (s <<< pcre_pkg::FRAC_BITS)
                 + (65536 - wa) * {48'd0, est_ping_avg} + 32768) >>> 16;
        end
        if (nxt > top) nxt = top;
        est_ping_avg   = nxt[15:0];
        est_ping_shown = s[7:0];
        est_fresh_ping = 1'b1;
      end
      pcre_pkg::OP_FRAME: begin
        est_peer_frame  = cf;
        est_fresh_frame = 1'b1;
      end
      pcre_pkg::OP_TICK: if (est_fresh_ping && est_fresh_frame) begin
        pf64 = {32'd0, est_peer_frame};
        sf64 = {32'd0, sf};
        raw = (pf64 <<< pcre_pkg::FRAC_BITS)
              + {48'd0, est_ping_avg >> pcre_pkg::FRAME_SHIFT}
              - (sf64 <<< pcre_pkg::FRAC_BITS);
        if (raw > RAW_MAX) raw = RAW_MAX;
        if (raw < RAW_MIN) raw = RAW_MIN;
        avg = est_rift_avg;
        if (!est_rift_seen) begin
          // first rift loads exactly, last raw left alone
          est_rift_seen = 1'b1;
          avg = raw;
        end else begin
          est_last_raw = raw[31:0];
          if (mag(raw) < (64'sd1 <<< pcre_pkg::FRAC_BITS)) begin
            avg = avg / 2;
            if (mag(avg) * 100 < (64'sd1 <<< pcre_pkg::FRAC_BITS)) avg = 0;
          end else begin
            wb = {48'd0, cfg_rift_weight};
            avg = (wb * raw + (65536 - wb) * avg + 32768) >>> 16;
          end
        end
        lim = {51'd0, cfg_rift_limit};
        if (avg > lim) avg = lim;
        if (avg < -lim) avg = -lim;
        est_rift_avg    = avg[13:0];
        est_ping_shown  = est_ping_avg[15:8];
        est_fresh_ping  = 1'b0;
        est_fresh_frame = 1'b0;
        upd = 1'b1;
      end
      default: ;
    endcase
    rep.smoothed_ping = est_ping_avg;
    rep.reported_ping = est_ping_shown;
    rep.smooth_rift   = est_rift_avg;
    rep.raw_rift      = est_last_raw;
    rep.rift_updated  = upd;
    pending_reports.insert(pending_reports.size(), rep);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [15:0] rtt,
                           input logic [31:0] cf, input logic [31:0] sf);
    int gap;
    gap = tx_idle ? $urandom_range(16, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {sf, cf, rtt};
    s_tuser  = op;
    do @(posedge clk); while (!s_tready);
    track_event(op, rtt, cf, sf);
  endtask

  // ping and frame in either order, then a tick that sees both fresh
  task automatic send_triple(input logic [15:0] rtt, input logic [31:0] pf, input int mode);
    logic [31:0] sf;
    logic [10:0] q;
    int k;
    if (mode != RIFT_WIDE) begin
      // keep sf = pf + k from wrapping
      if (pf < 32'd64) pf = pf + 32'd64;
      if (pf > 32'hFFFF_FFBF) pf = pf - 32'd64;
    end
    if ($urandom_range(1, 0)) begin
      send_word(pcre_pkg::OP_PING, rtt, $urandom, $urandom);
      send_word(pcre_pkg::OP_FRAME, 16'($urandom), pf, $urandom);
    end else begin
      send_word(pcre_pkg::OP_FRAME, 16'($urandom), pf, $urandom);
      send_word(pcre_pkg::OP_PING, rtt, $urandom, $urandom);
    end
    q = 11'(est_ping_avg >> pcre_pkg::FRAME_SHIFT);
    case (mode)
      RIFT_SMALL: sf = pf + q[10:8] + $urandom_range(1, 0);
      RIFT_NEAR: begin
        k = $urandom_range(80, 0);
        sf = pf + q[10:8] + k - 40;
      end
      default: sf = $urandom;
    endcase
    send_word(pcre_pkg::OP_TICK, 16'($urandom), $urandom, sf);
  endtask

  // sender stops and every expected word has come back
  task automatic wait_idle;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] word;
    word = $urandom;  // junk above the field
    case (idx)
      pcre_pkg::REG_PING_WEIGHT: begin
        word[15:0] = val[15:0]; cfg_ping_weight = val[15:0];
      end
      pcre_pkg::REG_RIFT_WEIGHT: begin
        word[15:0] = val[15:0]; cfg_rift_weight = val[15:0];
      end
      pcre_pkg::REG_PING_CAP: begin
        word[7:0] = val[7:0]; cfg_ping_cap = val[7:0];
      end
      default: begin
        word[12:0] = val[12:0]; cfg_rift_limit = val[12:0];
      end
    endcase
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = word;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic write_all(input logic [15:0] pa, input logic [15:0] ra,
                           input logic [7:0] cap, input logic [12:0] lim);
    write_reg(pcre_pkg::REG_PING_WEIGHT, {16'd0, pa});
    write_reg(pcre_pkg::REG_RIFT_WEIGHT, {16'd0, ra});
    write_reg(pcre_pkg::REG_PING_CAP, {24'd0, cap});
    write_reg(pcre_pkg::REG_RIFT_LIMIT, {19'd0, lim});
  endtask

  task automatic run_random(input int n);
    int done, r, mode;
    logic [1:0]  op;
    logic [15:0] rtt;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99, 0);
      if (r < 78) begin
        r = $urandom_range(9, 0);
        mode = (r < 4) ? RIFT_SMALL : (r < 8) ? RIFT_NEAR : RIFT_WIDE;
        rtt = ($urandom_range(9, 0) != 0) ? 16'($urandom_range(300, 0))
                                          : 16'($urandom_range(32767, 0));
        send_triple(rtt, $urandom, mode);
        done += 3;
      end else begin
        // loose word: any op, any content
        op  = 2'($urandom_range(3, 0));
        rtt = 16'($urandom);
        if (op == pcre_pkg::OP_FRAME || (op == pcre_pkg::OP_PING && !rtt[15]) ||
            (op == pcre_pkg::OP_TICK && est_fresh_ping && est_fresh_frame))
          done++;
        send_word(op, rtt, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_directed;
    send_word(pcre_pkg::OP_TICK, 16'($urandom), $urandom, 32'd0);  // nothing fresh
    send_word(pcre_pkg::OP_NOP, 16'($urandom), $urandom, $urandom);
    send_word(pcre_pkg::OP_PING, 16'h8000, $urandom, $urandom);    // negative, dropped
    send_word(pcre_pkg::OP_PING, 16'h7FFF, $urandom, $urandom);    // capped, first load
    send_word(pcre_pkg::OP_PING, 16'h0000, $urandom, $urandom);
    send_word(pcre_pkg::OP_FRAME, 16'($urandom), 32'hFFFF_FFFF, $urandom);
    send_word(pcre_pkg::OP_TICK, 16'($urandom), $urandom, 32'd0);  // first rift, saturates high
    send_word(pcre_pkg::OP_FRAME, 16'($urandom), 32'd0, $urandom);
    send_word(pcre_pkg::OP_TICK, 16'($urandom), $urandom, 32'd0);  // ping not fresh
    send_word(pcre_pkg::OP_PING, 16'h7FFF, $urandom, $urandom);
    send_word(pcre_pkg::OP_TICK, 16'($urandom), $urandom, 32'hFFFF_FFFF); // saturates low
    wait_idle();
    // tight limit so a few halvings reach the snap to zero
    write_reg(pcre_pkg::REG_RIFT_LIMIT, 32'd6);
    repeat (3) send_triple(16'd10, $urandom, RIFT_SMALL);
    send_triple(16'd200, $urandom, RIFT_NEAR);
    wait_idle();
    write_reg(pcre_pkg::REG_RIFT_LIMIT, {19'd0, pcre_pkg::RIFT_LIMIT_RST});
  endtask

  task automatic test_settings;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: write_all(16'd0, 16'd0, 8'd255, 13'd8191);
        1: write_all(16'hFFFF, 16'hFFFF, 8'd0, 13'd0);
        2: write_all(16'hFFFF, 16'd1, 8'd255, 13'd8191);
        3: write_all(16'd1, 16'hFFFF, 8'd31, 13'd100);
        7: write_all(pcre_pkg::PING_WEIGHT_RST, pcre_pkg::RIFT_WEIGHT_RST,
                     pcre_pkg::PING_CAP_RST, pcre_pkg::RIFT_LIMIT_RST);
        default: write_all(16'($urandom), 16'($urandom), 8'($urandom), 13'($urandom));
      endcase
      // one phase with no idling on either side
      tx_idle = (ph != 4);
      rx_idle = (ph != 4);
      run_random(230);
    end
    tx_idle = 1;
    rx_idle = 1;
  endtask

  task automatic test_backpressure;
    wait_idle();
    tx_idle = 0;
    hold_len = 300;
    repeat (15) send_triple(16'($urandom_range(255, 0)), $urandom, RIFT_NEAR);
    tx_idle = 1;
    wait_idle();
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = rx_idle ? $urandom_range(16, 0) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_results
    rift_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result word %h user %b", $time, m_tdata, m_tuser);
        bad_words++;
      end else begin
        want = pending_reports.pop_front();
        if (m_tdata[15:0] !== want.smoothed_ping) begin
          $display("%0t: smoothed_ping exp %h got %h", $time, want.smoothed_ping, m_tdata[15:0]);
          bad_words++;
        end
        if (m_tdata[23:16] !== want.reported_ping) begin
          $display("%0t: reported_ping exp %h got %h", $time, want.reported_ping,
                   m_tdata[23:16]);
          bad_words++;
        end
        if (m_tdata[37:24] !== want.smooth_rift) begin
          $display("%0t: smooth_rift exp %h got %h", $time, want.smooth_rift, m_tdata[37:24]);
          bad_words++;
        end
        if (m_tdata[69:38] !== want.raw_rift) begin
          $display("%0t: raw_rift exp %h got %h", $time, want.raw_rift, m_tdata[69:38]);
          bad_words++;
        end
        if (m_tuser[0] !== want.rift_updated) begin
          $display("%0t: rift_updated exp %b got %b", $time, want.rift_updated, m_tuser[0]);
          bad_words++;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = pcre_pkg::OP_NOP;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_estimate();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_settings();
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (bad_words == 0) begin
      $display("ping_and_clock_rift_estimator_core: match");
    end else begin
      $display("ping_and_clock_rift_estimator_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
